[src/assert_macros.svh]
// assertion helpers used by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/ptds_pkg.sv]
`timescale 1ns / 1ps

package ptds_pkg;

    // table sizes
    localparam int PRIO_SLOTS   = 4;
    localparam int COMMON_SLOTS = 8;
    localparam int ALL_SLOTS    = PRIO_SLOTS + COMMON_SLOTS;

    // index and count widths
    localparam int PW  = (PRIO_SLOTS > 1) ? $clog2(PRIO_SLOTS) : 1;
    localparam int PCW = $clog2(PRIO_SLOTS + 1);
    localparam int CW  = (COMMON_SLOTS > 1) ? $clog2(COMMON_SLOTS) : 1;
    localparam int CCW = $clog2(COMMON_SLOTS + 1);
    localparam int SW  = $clog2(ALL_SLOTS);
    localparam int QCW = $clog2(ALL_SLOTS + 1);

    // stream widths
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 24;

    localparam logic [7:0] NEVER_EXPIRES = 8'hFF;

    // request types
    localparam logic [1:0] REQ_REGISTER   = 2'd0;
    localparam logic [1:0] REQ_UNREGISTER = 2'd1;
    localparam logic [1:0] REQ_DISPATCH   = 2'd2;

    // task classes
    localparam logic [1:0] CLASS_PRIO   = 2'd0;
    localparam logic [1:0] CLASS_COMMON = 2'd1;
    localparam logic [1:0] CLASS_IDLE   = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_RUN    = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // slot flag bits
    localparam int FL_USED = 0;
    localparam int FL_ADD  = 1;
    localparam int FL_REM  = 2;
    localparam logic [2:0] FLAGS_NEW    = 3'b011;
    localparam logic [2:0] FLAGS_ACTIVE = 3'b001;
    localparam logic [2:0] FLAGS_FREE   = 3'b000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] id;
        logic [1:0]  cls;
        logic [1:0]  status;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] period;
        logic [7:0]  rep;
        logic [31:0] last_run;
    } cmn_entry_t;

endpackage

[src/ptds_obuf.sv]
`timescale 1ns / 1ps

module ptds_obuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ptds_pkg::result_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output ptds_pkg::result_t out_item
);
    import ptds_pkg::*;

    logic    valid_reg;
    result_t item_reg;

    // slot frees when empty or being drained this cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // held item
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

[src/periodic_task_dispatch_scheduler.sv]
`timescale 1ns / 1ps

// Periodic task scheduler. Register, unregister and dispatch requests enter
// on the s_ stream one at a time; results leave on the m_ stream through a
// one-item output register, so the last result may wait while the next
// request is taken. Output stalls hold each step that emits an item. A
// register request, and a priority or idle-class unregister, answer with a
// single status item. A common-class unregister scans the common slot memory
// slot by slot (read, then compare) before its status item. A dispatch emits
// one run item per priority task each time the priority list is walked
// (once, then once after every common task), reads and due-tests each common
// slot of the snapshot (a common run item leaves in the due test), sweeps
// every slot (ALL_SLOTS) for deferred removals, applies the queued adds in
// order, and ends with the idle and done steps. The common slot payload
// (id, period, repeat, last run) lives in a one-port synchronous memory with
// a registered read; no access pattern reads an entry in the cycle it is
// written.
module periodic_task_dispatch_scheduler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // task_class, task_id, period, task_priority, repeat_count, now_ms
    input  logic [ptds_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // run_task_id, run_class, status
    output logic [ptds_pkg::M_TDATA_W-1:0] m_tdata,
    // result_kind
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast
);
    import ptds_pkg::*;

`include "assert_macros.svh"

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_REG   = 4'd1;
    localparam logic [3:0] S_UNR   = 4'd2;
    localparam logic [3:0] S_URD   = 4'd3;
    localparam logic [3:0] S_UCMP  = 4'd4;
    localparam logic [3:0] S_USTAT = 4'd5;
    localparam logic [3:0] S_PRIO  = 4'd6;
    localparam logic [3:0] S_CRD   = 4'd7;
    localparam logic [3:0] S_CCHK  = 4'd8;
    localparam logic [3:0] S_REM   = 4'd9;
    localparam logic [3:0] S_ADD   = 4'd10;
    localparam logic [3:0] S_IDL   = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0] state_reg, state_next;

    // latched request
    logic [1:0]  rq_class_reg;
    logic [15:0] rq_id_reg;
    logic [31:0] rq_period_reg, rq_now_reg;
    logic [7:0]  rq_lvl_reg, rq_rep_reg;

    // priority table
    logic [15:0]  prio_ids_reg [PRIO_SLOTS];
    logic [15:0]  prio_ids_next [PRIO_SLOTS];
    logic [7:0]   prio_lvl_reg [PRIO_SLOTS];
    logic [7:0]   prio_lvl_next [PRIO_SLOTS];
    logic [PW-1:0] prio_ord_reg [PRIO_SLOTS];
    logic [PW-1:0] prio_ord_next [PRIO_SLOTS];
    logic [7:0]   prio_olv_reg [PRIO_SLOTS];
    logic [7:0]   prio_olv_next [PRIO_SLOTS];
    logic [PCW-1:0] prio_cnt_reg, prio_cnt_next;

    // common table, ordering part
    logic [7:0]   cmn_lvl_reg [COMMON_SLOTS];
    logic [7:0]   cmn_lvl_next [COMMON_SLOTS];
    logic [CW-1:0] cmn_ord_reg [COMMON_SLOTS];
    logic [CW-1:0] cmn_ord_next [COMMON_SLOTS];
    logic [7:0]   cmn_olv_reg [COMMON_SLOTS];
    logic [7:0]   cmn_olv_next [COMMON_SLOTS];
    logic [CCW-1:0] cmn_cnt_reg, cmn_cnt_next;

    // slot flags and pending add queue
    logic [2:0]    flags_reg [ALL_SLOTS];
    logic [2:0]    flags_next [ALL_SLOTS];
    logic [SW-1:0] q_reg [ALL_SLOTS];
    logic [SW-1:0] q_next [ALL_SLOTS];
    logic [QCW-1:0] qlen_reg, qlen_next;

    // idle slot
    logic        idle_valid_reg, idle_valid_next;
    logic [15:0] idle_id_reg, idle_id_next;

    // walk counters
    logic [CW-1:0]  snap_reg [COMMON_SLOTS];
    logic [CW-1:0]  snap_next [COMMON_SLOTS];
    logic [CCW-1:0] snap_cnt_reg, snap_cnt_next;
    logic [CCW-1:0] ci_reg, ci_next;
    logic [PCW-1:0] pk_reg, pk_next;
    logic [SW-1:0]  rs_reg, rs_next;
    logic [QCW-1:0] qk_reg, qk_next;
    logic [CW-1:0]  us_reg, us_next;
    logic           hit_reg, hit_next;

    // common slot memory
    cmn_entry_t    cmn_mem [COMMON_SLOTS];
    cmn_entry_t    rd_data_reg;
    logic          mem_we, mem_re;
    logic [CW-1:0] mem_waddr, mem_raddr;
    cmn_entry_t    mem_wdata;

    // list edit controls
    logic          p_rm, p_ins, c_rm, c_ins;
    logic [PW-1:0] p_slot;
    logic [CW-1:0] c_slot;
    logic [PRIO_SLOTS-1:0]   p_hit, p_gt, p_shift;
    logic [COMMON_SLOTS-1:0] c_hit, c_gt, c_shift;
    logic [PW-1:0]  p_ord_ed [PRIO_SLOTS];
    logic [7:0]     p_olv_ed [PRIO_SLOTS];
    logic [PCW-1:0] p_cnt_ed;
    logic [CW-1:0]  c_ord_ed [COMMON_SLOTS];
    logic [7:0]     c_olv_ed [COMMON_SLOTS];
    logic [CCW-1:0] c_cnt_ed;

    // free slot search and unregister hits
    logic          p_free_found, c_free_found;
    logic [PW-1:0] p_free;
    logic [CW-1:0] c_free;
    logic [PRIO_SLOTS-1:0] p_unr_hit;

    // output handoff
    logic    emit_valid, emit_ready;
    result_t emit_item, out_item;

    logic s_accept;
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // free slot search and priority unregister match
    always_comb
    begin
        p_free_found = 1'b0;
        p_free       = '0;
        c_free_found = 1'b0;
        c_free       = '0;
        for (int s = 0; s < PRIO_SLOTS; s++)
        begin
            if (!p_free_found && !flags_reg[s][FL_USED])
            begin
                p_free_found = 1'b1;
                p_free       = PW'(s);
            end
            p_unr_hit[s] = flags_reg[s][FL_USED] && !flags_reg[s][FL_ADD]
                           && (prio_ids_reg[s] == rq_id_reg);
        end
        for (int s = 0; s < COMMON_SLOTS; s++)
        begin
            if (!c_free_found && !flags_reg[PRIO_SLOTS + s][FL_USED])
            begin
                c_free_found = 1'b1;
                c_free       = CW'(s);
            end
        end
    end

    // priority list edit: remove a slot or insert one in level order
    always_comb
    begin
        logic seen;
        logic prev_gt;
        seen    = 1'b0;
        prev_gt = 1'b1;
        for (int k = 0; k < PRIO_SLOTS; k++)
        begin
            p_hit[k]   = (PCW'(k) < prio_cnt_reg) && (prio_ord_reg[k] == p_slot);
            p_gt[k]    = (PCW'(k) < prio_cnt_reg) && (prio_olv_reg[k] > prio_lvl_reg[p_slot]);
            seen       = seen | p_hit[k];
            p_shift[k] = seen;
        end
        p_ord_ed = prio_ord_reg;
        p_olv_ed = prio_olv_reg;
        p_cnt_ed = prio_cnt_reg;
        if (p_rm)
        begin
            for (int k = 0; k < PRIO_SLOTS; k++)
            begin
                if (p_shift[k] && (k + 1 < PRIO_SLOTS))
                begin
                    p_ord_ed[k] = prio_ord_reg[(k + 1 < PRIO_SLOTS) ? k + 1 : k];
                    p_olv_ed[k] = prio_olv_reg[(k + 1 < PRIO_SLOTS) ? k + 1 : k];
                end
            end
            if (|p_hit)
            begin
                p_cnt_ed = prio_cnt_reg - PCW'(1);
            end
        end
        else if (p_ins)
        begin
            for (int k = 0; k < PRIO_SLOTS; k++)
            begin
                if (!p_gt[k])
                begin
                    if (prev_gt)
                    begin
                        p_ord_ed[k] = p_slot;
                        p_olv_ed[k] = prio_lvl_reg[p_slot];
                    end
                    else
                    begin
                        p_ord_ed[k] = prio_ord_reg[(k > 0) ? k - 1 : 0];
                        p_olv_ed[k] = prio_olv_reg[(k > 0) ? k - 1 : 0];
                    end
                end
                prev_gt = p_gt[k];
            end
            p_cnt_ed = prio_cnt_reg + PCW'(1);
        end
    end

    // common list edit
    always_comb
    begin
        logic seen;
        logic prev_gt;
        seen    = 1'b0;
        prev_gt = 1'b1;
        for (int k = 0; k < COMMON_SLOTS; k++)
        begin
            c_hit[k]   = (CCW'(k) < cmn_cnt_reg) && (cmn_ord_reg[k] == c_slot);
            c_gt[k]    = (CCW'(k) < cmn_cnt_reg) && (cmn_olv_reg[k] > cmn_lvl_reg[c_slot]);
            seen       = seen | c_hit[k];
            c_shift[k] = seen;
        end
        c_ord_ed = cmn_ord_reg;
        c_olv_ed = cmn_olv_reg;
        c_cnt_ed = cmn_cnt_reg;
        if (c_rm)
        begin
            for (int k = 0; k < COMMON_SLOTS; k++)
            begin
                if (c_shift[k] && (k + 1 < COMMON_SLOTS))
                begin
                    c_ord_ed[k] = cmn_ord_reg[(k + 1 < COMMON_SLOTS) ? k + 1 : k];
                    c_olv_ed[k] = cmn_olv_reg[(k + 1 < COMMON_SLOTS) ? k + 1 : k];
                end
            end
            if (|c_hit)
            begin
                c_cnt_ed = cmn_cnt_reg - CCW'(1);
            end
        end
        else if (c_ins)
        begin
            for (int k = 0; k < COMMON_SLOTS; k++)
            begin
                if (!c_gt[k])
                begin
                    if (prev_gt)
                    begin
                        c_ord_ed[k] = c_slot;
                        c_olv_ed[k] = cmn_lvl_reg[c_slot];
                    end
                    else
                    begin
                        c_ord_ed[k] = cmn_ord_reg[(k > 0) ? k - 1 : 0];
                        c_olv_ed[k] = cmn_olv_reg[(k > 0) ? k - 1 : 0];
                    end
                end
                prev_gt = c_gt[k];
            end
            c_cnt_ed = cmn_cnt_reg + CCW'(1);
        end
    end

    // sequencer
    always_comb
    begin
        logic [SW-1:0] fidx;
        logic [CW-1:0] cs;
        logic [SW-1:0] qs;
        logic          due;
        fidx = '0;
        cs   = '0;
        qs   = '0;
        due  = 1'b0;

        state_next      = state_reg;
        prio_ids_next   = prio_ids_reg;
        prio_lvl_next   = prio_lvl_reg;
        cmn_lvl_next    = cmn_lvl_reg;
        flags_next      = flags_reg;
        q_next          = q_reg;
        qlen_next       = qlen_reg;
        idle_valid_next = idle_valid_reg;
        idle_id_next    = idle_id_reg;
        snap_next       = snap_reg;
        snap_cnt_next   = snap_cnt_reg;
        ci_next         = ci_reg;
        pk_next         = pk_reg;
        rs_next         = rs_reg;
        qk_next         = qk_reg;
        us_next         = us_reg;
        hit_next        = hit_reg;

        emit_valid = 1'b0;
        emit_item  = '0;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = rd_data_reg;
        mem_re     = 1'b0;
        mem_raddr  = '0;
        p_rm       = 1'b0;
        p_ins      = 1'b0;
        p_slot     = '0;
        c_rm       = 1'b0;
        c_ins      = 1'b0;
        c_slot     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    case (s_tuser)
                        REQ_REGISTER:   state_next = S_REG;
                        REQ_UNREGISTER: state_next = S_UNR;
                        REQ_DISPATCH:
                        begin
                            snap_next     = cmn_ord_reg;
                            snap_cnt_next = cmn_cnt_reg;
                            ci_next       = '0;
                            pk_next       = '0;
                            state_next    = S_PRIO;
                        end
                        default:        state_next = S_IDLE;
                    endcase
                end
            end

            // register: status item and table write in the same cycle
            S_REG:
            begin
                emit_valid     = 1'b1;
                emit_item.kind = KIND_STATUS;
                emit_item.last = 1'b1;
                case (rq_class_reg)
                    CLASS_PRIO:   emit_item.status = p_free_found ? ST_OK : ST_FULL;
                    CLASS_COMMON: emit_item.status = c_free_found ? ST_OK : ST_FULL;
                    CLASS_IDLE:   emit_item.status = idle_valid_reg ? ST_FULL : ST_OK;
                    default:      emit_item.status = ST_FULL;
                endcase
                if (emit_ready)
                begin
                    state_next = S_IDLE;
                    if (rq_class_reg == CLASS_PRIO && p_free_found)
                    begin
                        prio_ids_next[p_free]       = rq_id_reg;
                        prio_lvl_next[p_free]       = rq_lvl_reg;
                        flags_next[SW'(p_free)]     = FLAGS_NEW;
                        q_next[qlen_reg[SW-1:0]]    = SW'(p_free);
                        qlen_next                   = qlen_reg + QCW'(1);
                    end
                    else if (rq_class_reg == CLASS_COMMON && c_free_found)
                    begin
                        fidx                        = SW'(PRIO_SLOTS) + SW'(c_free);
                        cmn_lvl_next[c_free]        = rq_lvl_reg;
                        flags_next[fidx]            = FLAGS_NEW;
                        q_next[qlen_reg[SW-1:0]]    = fidx;
                        qlen_next                   = qlen_reg + QCW'(1);
                        mem_we                      = 1'b1;
                        mem_waddr                   = c_free;
                        mem_wdata.id                = rq_id_reg;
                        mem_wdata.period            = rq_period_reg;
                        mem_wdata.rep               = rq_rep_reg;
                        mem_wdata.last_run          = rq_now_reg;
                    end
                    else if (rq_class_reg == CLASS_IDLE && !idle_valid_reg)
                    begin
                        idle_valid_next = 1'b1;
                        idle_id_next    = rq_id_reg;
                    end
                end
            end

            // unregister: priority and idle answer at once, common scans memory
            S_UNR:
            begin
                if (rq_class_reg == CLASS_COMMON)
                begin
                    us_next    = '0;
                    hit_next   = 1'b0;
                    state_next = S_URD;
                end
                else
                begin
                    emit_valid     = 1'b1;
                    emit_item.kind = KIND_STATUS;
                    emit_item.last = 1'b1;
                    case (rq_class_reg)
                        CLASS_PRIO: emit_item.status = (|p_unr_hit) ? ST_OK : ST_NOT_FOUND;
                        CLASS_IDLE:
                        begin
                            emit_item.status = (idle_valid_reg && idle_id_reg == rq_id_reg)
                                               ? ST_OK : ST_NOT_FOUND;
                        end
                        default:    emit_item.status = ST_NOT_FOUND;
                    endcase
                    if (emit_ready)
                    begin
                        state_next = S_IDLE;
                        if (rq_class_reg == CLASS_PRIO)
                        begin
                            for (int s = 0; s < PRIO_SLOTS; s++)
                            begin
                                if (p_unr_hit[s])
                                begin
                                    flags_next[s][FL_REM] = 1'b1;
                                end
                            end
                        end
                        else if (rq_class_reg == CLASS_IDLE && idle_valid_reg
                                 && idle_id_reg == rq_id_reg)
                        begin
                            idle_valid_next = 1'b0;
                        end
                    end
                end
            end

            S_URD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = us_reg;
                state_next = S_UCMP;
            end

            // mark every listed copy with a matching id
            S_UCMP:
            begin
                fidx = SW'(PRIO_SLOTS) + SW'(us_reg);
                if (flags_reg[fidx][FL_USED] && !flags_reg[fidx][FL_ADD]
                    && rd_data_reg.id == rq_id_reg)
                begin
                    flags_next[fidx][FL_REM] = 1'b1;
                    hit_next                 = 1'b1;
                end
                if (us_reg == CW'(COMMON_SLOTS - 1))
                begin
                    state_next = S_USTAT;
                end
                else
                begin
                    us_next    = us_reg + CW'(1);
                    state_next = S_URD;
                end
            end

            S_USTAT:
            begin
                emit_valid       = 1'b1;
                emit_item.kind   = KIND_STATUS;
                emit_item.status = hit_reg ? ST_OK : ST_NOT_FOUND;
                emit_item.last   = 1'b1;
                if (emit_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            // one run item per priority task
            S_PRIO:
            begin
                if (pk_reg < prio_cnt_reg)
                begin
                    emit_valid     = 1'b1;
                    emit_item.kind = KIND_RUN;
                    emit_item.id   = prio_ids_reg[prio_ord_reg[pk_reg[PW-1:0]]];
                    emit_item.cls  = CLASS_PRIO;
                    if (emit_ready)
                    begin
                        pk_next = pk_reg + PCW'(1);
                    end
                end
                else
                begin
                    state_next = S_CRD;
                end
            end

            // fetch next common task of the snapshot
            S_CRD:
            begin
                if (ci_reg == snap_cnt_reg)
                begin
                    rs_next    = '0;
                    state_next = S_REM;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = snap_reg[ci_reg[CW-1:0]];
                    state_next = S_CCHK;
                end
            end

            // due test, run item and repeat bookkeeping
            S_CCHK:
            begin
                cs   = snap_reg[ci_reg[CW-1:0]];
                fidx = SW'(PRIO_SLOTS) + SW'(cs);
                due  = flags_reg[fidx][FL_USED]
                       && ((rq_now_reg - rd_data_reg.last_run) >= rd_data_reg.period);
                if (due)
                begin
                    emit_valid     = 1'b1;
                    emit_item.kind = KIND_RUN;
                    emit_item.id   = rd_data_reg.id;
                    emit_item.cls  = CLASS_COMMON;
                end
                if (!due || emit_ready)
                begin
                    ci_next    = ci_reg + CCW'(1);
                    pk_next    = '0;
                    state_next = S_PRIO;
                    if (due)
                    begin
                        if (rd_data_reg.rep == 8'd0)
                        begin
                            c_rm             = 1'b1;
                            c_slot           = cs;
                            flags_next[fidx] = FLAGS_FREE;
                        end
                        else
                        begin
                            mem_we             = 1'b1;
                            mem_waddr          = cs;
                            mem_wdata.last_run = rq_now_reg;
                            if (rd_data_reg.rep != NEVER_EXPIRES)
                            begin
                                mem_wdata.rep = rd_data_reg.rep - 8'd1;
                            end
                        end
                    end
                end
            end

            // deferred removals, one slot a cycle
            S_REM:
            begin
                if (flags_reg[rs_reg][FL_REM])
                begin
                    if (rs_reg < SW'(PRIO_SLOTS))
                    begin
                        p_rm   = 1'b1;
                        p_slot = PW'(rs_reg);
                    end
                    else
                    begin
                        c_rm   = 1'b1;
                        c_slot = CW'(rs_reg - SW'(PRIO_SLOTS));
                    end
                    flags_next[rs_reg] = FLAGS_FREE;
                end
                if (rs_reg == SW'(ALL_SLOTS - 1))
                begin
                    qk_next    = '0;
                    state_next = S_ADD;
                end
                else
                begin
                    rs_next = rs_reg + SW'(1);
                end
            end

            // deferred adds in request order
            S_ADD:
            begin
                if (qk_reg == qlen_reg)
                begin
                    qlen_next  = '0;
                    state_next = S_IDL;
                end
                else
                begin
                    qs = q_reg[qk_reg[SW-1:0]];
                    if (flags_reg[qs][FL_ADD])
                    begin
                        if (qs < SW'(PRIO_SLOTS))
                        begin
                            p_ins  = 1'b1;
                            p_slot = PW'(qs);
                        end
                        else
                        begin
                            c_ins  = 1'b1;
                            c_slot = CW'(qs - SW'(PRIO_SLOTS));
                        end
                        flags_next[qs] = FLAGS_ACTIVE;
                    end
                    qk_next = qk_reg + QCW'(1);
                end
            end

            S_IDL:
            begin
                if (idle_valid_reg)
                begin
                    emit_valid     = 1'b1;
                    emit_item.kind = KIND_RUN;
                    emit_item.id   = idle_id_reg;
                    emit_item.cls  = CLASS_IDLE;
                end
                if (!idle_valid_reg || emit_ready)
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                emit_valid     = 1'b1;
                emit_item.kind = KIND_DONE;
                emit_item.last = 1'b1;
                if (emit_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prio_ord_reg   <= '{default: '0};
            prio_olv_reg   <= '{default: '0};
            prio_cnt_reg   <= '0;
            cmn_ord_reg    <= '{default: '0};
            cmn_olv_reg    <= '{default: '0};
            cmn_cnt_reg    <= '0;
            flags_reg      <= '{default: '0};
            q_reg          <= '{default: '0};
            qlen_reg       <= '0;
            idle_valid_reg <= 1'b0;
            snap_cnt_reg   <= '0;
            ci_reg         <= '0;
            pk_reg         <= '0;
            rs_reg         <= '0;
            qk_reg         <= '0;
            us_reg         <= '0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prio_ord_reg   <= p_ord_ed;
            prio_olv_reg   <= p_olv_ed;
            prio_cnt_reg   <= p_cnt_ed;
            cmn_ord_reg    <= c_ord_ed;
            cmn_olv_reg    <= c_olv_ed;
            cmn_cnt_reg    <= c_cnt_ed;
            flags_reg      <= flags_next;
            q_reg          <= q_next;
            qlen_reg       <= qlen_next;
            idle_valid_reg <= idle_valid_next;
            snap_cnt_reg   <= snap_cnt_next;
            ci_reg         <= ci_next;
            pk_reg         <= pk_next;
            rs_reg         <= rs_next;
            qk_reg         <= qk_next;
            us_reg         <= us_next;
            hit_reg        <= hit_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prio_ids_reg <= prio_ids_next;
        prio_lvl_reg <= prio_lvl_next;
        cmn_lvl_reg  <= cmn_lvl_next;
        idle_id_reg  <= idle_id_next;
        snap_reg     <= snap_next;
        if (s_accept)
        begin
            rq_class_reg  <= s_tdata[1:0];
            rq_id_reg     <= s_tdata[17:2];
            rq_period_reg <= s_tdata[49:18];
            rq_lvl_reg    <= s_tdata[57:50];
            rq_rep_reg    <= s_tdata[65:58];
            rq_now_reg    <= s_tdata[97:66];
        end
    end

    // common slot memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cmn_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= cmn_mem[mem_raddr];
        end
    end

    ptds_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (emit_valid),
        .in_ready  (emit_ready),
        .in_item   (emit_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    // stream packing
    assign m_tdata = {4'd0, out_item.status, out_item.cls, out_item.id};
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.last;

    `ASSERT_ALWAYS(a_prio_cnt_range, prio_cnt_reg <= PCW'(PRIO_SLOTS),
        "priority list longer than its table")
    `ASSERT_ALWAYS(a_qlen_range, qlen_reg <= QCW'(ALL_SLOTS),
        "pending add queue overflow")
    `ASSERT_IMPLIES(a_done_last, emit_valid && emit_item.kind == KIND_DONE, emit_item.last,
        "done item without last")
    `ASSERT_NEXT(a_add_drains_queue, state_reg == S_ADD && qk_reg == qlen_reg,
        qlen_reg == '0, "pending queue not emptied after add phase")

endmodule

[verif/ptds_checker.sv]
`timescale 1ns / 1ps

module ptds_checker
    import ptds_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [1:0]           m_tuser,
    input  logic                 m_tlast,
    output int                   errors,
    output int                   waiting
);

    // scheduler state as predicted
    logic [15:0] prio_id [PRIO_SLOTS];
    logic [7:0]  prio_lv [PRIO_SLOTS];
    int          prio_ord [PRIO_SLOTS];
    int          prio_cnt;
    logic [15:0] cmn_id [COMMON_SLOTS];
    logic [7:0]  cmn_lv [COMMON_SLOTS];
    logic [31:0] cmn_per [COMMON_SLOTS];
    logic [7:0]  cmn_rep [COMMON_SLOTS];
    logic [31:0] cmn_last [COMMON_SLOTS];
    int          cmn_ord [COMMON_SLOTS];
    int          cmn_cnt;
    logic [2:0]  flags [ALL_SLOTS];
    int          add_q [ALL_SLOTS];
    int          add_len;
    logic        idle_ok;
    logic [15:0] idle_id;

    result_t expected_results[$];

    assign waiting = expected_results.size();

    function automatic void push_result(logic [1:0] kind, logic [15:0] id, logic [1:0] cls,
                                        logic [1:0] st, logic last);
        result_t r;
        r.kind = kind;
        r.id = id;
        r.cls = cls;
        r.status = st;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    function automatic void emit_prio_runs();
        for (int k = 0; k < prio_cnt; k++)
            push_result(KIND_RUN, prio_id[prio_ord[k]], CLASS_PRIO, ST_OK, 1'b0);
    endfunction

    // unlink a slot from one ordered list
    function automatic void unlink(bit cmn, int slot);
        int n;
        n = cmn ? cmn_cnt : prio_cnt;
        for (int k = 0; k < n; k++) begin
            if ((cmn ? cmn_ord[k] : prio_ord[k]) == slot) begin
                for (int j = k; j + 1 < n; j++) begin
                    if (cmn) cmn_ord[j] = cmn_ord[j + 1];
                    else prio_ord[j] = prio_ord[j + 1];
                end
                if (cmn) cmn_cnt--;
                else prio_cnt--;
                return;
            end
        end
    endfunction

    // new slot goes ahead of equal levels
    function automatic void link(bit cmn, int slot);
        int n;
        int pos;
        n = cmn ? cmn_cnt : prio_cnt;
        pos = 0;
        if (n >= (cmn ? COMMON_SLOTS : PRIO_SLOTS)) return;
        if (cmn) begin
            while (pos < n && cmn_lv[cmn_ord[pos]] > cmn_lv[slot]) pos++;
            for (int j = n; j > pos; j--) cmn_ord[j] = cmn_ord[j - 1];
            cmn_ord[pos] = slot;
            cmn_cnt++;
        end else begin
            while (pos < n && prio_lv[prio_ord[pos]] > prio_lv[slot]) pos++;
            for (int j = n; j > pos; j--) prio_ord[j] = prio_ord[j - 1];
            prio_ord[pos] = slot;
            prio_cnt++;
        end
    endfunction

    function automatic void apply_deferred();
        for (int s = 0; s < PRIO_SLOTS; s++)
            if (flags[s][FL_REM]) begin
                unlink(1'b0, s);
                flags[s] = FLAGS_FREE;
            end
        for (int k = 0; k < add_len; k++)
            if (add_q[k] < PRIO_SLOTS && flags[add_q[k]][FL_ADD]) begin
                link(1'b0, add_q[k]);
                flags[add_q[k]] = FLAGS_ACTIVE;
            end
        for (int s = 0; s < COMMON_SLOTS; s++)
            if (flags[PRIO_SLOTS + s][FL_REM]) begin
                unlink(1'b1, s);
                flags[PRIO_SLOTS + s] = FLAGS_FREE;
            end
        for (int k = 0; k < add_len; k++)
            if (add_q[k] >= PRIO_SLOTS && flags[add_q[k]][FL_ADD]) begin
                link(1'b1, add_q[k] - PRIO_SLOTS);
                flags[add_q[k]] = FLAGS_ACTIVE;
            end
        add_len = 0;
    endfunction

    function automatic logic [1:0] register_task(logic [1:0] cls, logic [15:0] id,
                                                 logic [31:0] per, logic [7:0] lv,
                                                 logic [7:0] rep, logic [31:0] now);
        if (cls == CLASS_PRIO) begin
            for (int s = 0; s < PRIO_SLOTS; s++)
                if (!flags[s][FL_USED] && add_len < ALL_SLOTS) begin
                    prio_id[s] = id;
                    prio_lv[s] = lv;
                    flags[s] = FLAGS_NEW;
                    add_q[add_len++] = s;
                    return ST_OK;
                end
            return ST_FULL;
        end
        if (cls == CLASS_COMMON) begin
            for (int s = 0; s < COMMON_SLOTS; s++)
                if (!flags[PRIO_SLOTS + s][FL_USED] && add_len < ALL_SLOTS) begin
                    cmn_id[s] = id;
                    cmn_lv[s] = lv;
                    cmn_per[s] = per;
                    cmn_rep[s] = rep;
                    cmn_last[s] = now;
                    flags[PRIO_SLOTS + s] = FLAGS_NEW;
                    add_q[add_len++] = PRIO_SLOTS + s;
                    return ST_OK;
                end
            return ST_FULL;
        end
        if (cls == CLASS_IDLE) begin
            if (idle_ok) return ST_FULL;
            idle_ok = 1'b1;
            idle_id = id;
            return ST_OK;
        end
        return ST_FULL;
    endfunction

    function automatic logic [1:0] unregister_task(logic [1:0] cls, logic [15:0] id);
        int hits;
        hits = 0;
        if (cls == CLASS_PRIO) begin
            for (int k = 0; k < prio_cnt; k++)
                if (prio_id[prio_ord[k]] == id) begin
                    flags[prio_ord[k]][FL_REM] = 1'b1;
                    hits++;
                end
            return hits ? ST_OK : ST_NOT_FOUND;
        end
        if (cls == CLASS_COMMON) begin
            for (int k = 0; k < cmn_cnt; k++)
                if (cmn_id[cmn_ord[k]] == id) begin
                    flags[PRIO_SLOTS + cmn_ord[k]][FL_REM] = 1'b1;
                    hits++;
                end
            return hits ? ST_OK : ST_NOT_FOUND;
        end
        if (cls == CLASS_IDLE && idle_ok && idle_id == id) begin
            idle_ok = 1'b0;
            return ST_OK;
        end
        return ST_NOT_FOUND;
    endfunction

    function automatic void dispatch_pass(logic [31:0] now);
        int snap [COMMON_SLOTS];
        int n;
        int s;
        logic [31:0] elapsed;
        n = cmn_cnt;
        snap = cmn_ord;
        emit_prio_runs();
        for (int k = 0; k < n; k++) begin
            s = snap[k];
            elapsed = now - cmn_last[s];
            if (flags[PRIO_SLOTS + s][FL_USED] && elapsed >= cmn_per[s]) begin
                push_result(KIND_RUN, cmn_id[s], CLASS_COMMON, ST_OK, 1'b0);
                if (cmn_rep[s] == 8'd0) begin
                    unlink(1'b1, s);
                    flags[PRIO_SLOTS + s] = FLAGS_FREE;
                end else begin
                    cmn_last[s] = now;
                    if (cmn_rep[s] != NEVER_EXPIRES) cmn_rep[s]--;
                end
            end
            emit_prio_runs();
        end
        apply_deferred();
        if (idle_ok) push_result(KIND_RUN, idle_id, CLASS_IDLE, ST_OK, 1'b0);
        push_result(KIND_DONE, 16'd0, 2'd0, ST_OK, 1'b1);
    endfunction

    // predict on each accepted request item
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prio_cnt = 0;
            cmn_cnt = 0;
            add_len = 0;
            idle_ok = 1'b0;
            idle_id = '0;
            for (int s = 0; s < ALL_SLOTS; s++) flags[s] = FLAGS_FREE;
            for (int s = 0; s < PRIO_SLOTS; s++) prio_ord[s] = 0;
            for (int s = 0; s < COMMON_SLOTS; s++) cmn_ord[s] = 0;
        end else if (s_tvalid && s_tready) begin
            case (s_tuser)
                REQ_REGISTER:
                    push_result(KIND_STATUS, 16'd0, 2'd0,
                                register_task(s_tdata[1:0], s_tdata[17:2], s_tdata[49:18],
                                              s_tdata[57:50], s_tdata[65:58],
                                              s_tdata[97:66]), 1'b1);
                REQ_UNREGISTER:
                    push_result(KIND_STATUS, 16'd0, 2'd0,
                                unregister_task(s_tdata[1:0], s_tdata[17:2]), 1'b1);
                REQ_DISPATCH:
                    dispatch_pass(s_tdata[97:66]);
                default: ;
            endcase
        end
    end

    // compare each accepted result item
    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            errors <= 0;
        end else if (m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result item kind %0h data %0h", m_tuser, m_tdata);
                errors <= errors + 1;
            end else begin
                want = expected_results.pop_front();
                if (m_tuser !== want.kind || m_tdata[15:0] !== want.id ||
                    m_tdata[17:16] !== want.cls || m_tdata[19:18] !== want.status ||
                    m_tdata[23:20] !== 4'd0 || m_tlast !== want.last)
                    errors <= errors + 1;
                if (m_tuser !== want.kind)
                    $error("result_kind exp %0h act %0h", want.kind, m_tuser);
                if (m_tdata[15:0] !== want.id)
                    $error("run_task_id exp %0h act %0h", want.id, m_tdata[15:0]);
                if (m_tdata[17:16] !== want.cls)
                    $error("run_class exp %0h act %0h", want.cls, m_tdata[17:16]);
                if (m_tdata[19:18] !== want.status)
                    $error("status exp %0h act %0h", want.status, m_tdata[19:18]);
                if (m_tdata[23:20] !== 4'd0)
                    $error("tdata pad exp 0 act %0h", m_tdata[23:20]);
                if (m_tlast !== want.last)
                    $error("last exp %0h act %0h", want.last, m_tlast);
            end
        end
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import ptds_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 320;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    int                   errors;
    int                   waiting;
    int                   quiet_cycles;
    logic [31:0]          now_t;

    periodic_task_dispatch_scheduler u_top (.*);

    ptds_checker u_checker (.*);

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // result side: random stalls and one long hold-off
    initial begin
        int n;
        int taken;
        bit held;
        taken = 0;
        held = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (!held && taken > 250) begin
                n = 400;
                held = 1'b1;
            end
            if (n > 0) begin
                @(negedge clk) m_tready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            @(negedge clk) m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            taken++;
        end
    end

    task automatic send_request(logic [1:0] req, logic [1:0] cls, logic [15:0] id,
                                logic [31:0] per, logic [7:0] lv, logic [7:0] rep);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {6'd0, now_t, rep, lv, per, id, cls};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            @(negedge clk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic random_request();
        logic [1:0]  req;
        logic [1:0]  cls;
        logic [15:0] id;
        logic [31:0] per;
        logic [7:0]  rep;
        int pick;
        pick = $urandom_range(0, 99);
        req = (pick < 35) ? REQ_DISPATCH : (pick < 68) ? REQ_REGISTER :
              (pick < 95) ? REQ_UNREGISTER : 2'd3;
        pick = $urandom_range(0, 99);
        cls = (pick < 40) ? CLASS_PRIO : (pick < 85) ? CLASS_COMMON :
              (pick < 96) ? CLASS_IDLE : 2'd3;
        id = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 7)) : 16'($urandom);
        per = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 30) : $urandom;
        pick = $urandom_range(0, 3);
        rep = (pick == 0) ? 8'd0 : (pick == 1) ? 8'($urandom_range(1, 4)) :
              (pick == 2) ? NEVER_EXPIRES : 8'($urandom);
        // time mostly creeps forward, sometimes jumps anywhere
        if ($urandom_range(0, 19) == 0) now_t = $urandom;
        else now_t = now_t + $urandom_range(0, 20);
        send_request(req, cls, id, per, 8'($urandom), rep);
    endtask

    // stimulus and verdict
    initial begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = REQ_REGISTER;
        s_tdata = '0;
        now_t = 32'd100;
        repeat (3) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed: idle slot cases
        send_request(REQ_UNREGISTER, CLASS_IDLE, 16'h0001, 0, 0, 0);
        send_request(REQ_REGISTER, CLASS_IDLE, 16'hFFFF, 0, 0, 0);
        send_request(REQ_REGISTER, CLASS_IDLE, 16'h0002, 0, 0, 0);
        send_request(REQ_UNREGISTER, CLASS_IDLE, 16'h0002, 0, 0, 0);
        // priority table filled, equal levels and overflow
        send_request(REQ_REGISTER, CLASS_PRIO, 16'h0010, 0, 8'd0, 0);
        send_request(REQ_REGISTER, CLASS_PRIO, 16'h0011, 0, 8'd255, 0);
        send_request(REQ_REGISTER, CLASS_PRIO, 16'h0012, 0, 8'd255, 0);
        send_request(REQ_REGISTER, CLASS_PRIO, 16'h0011, 0, 8'd7, 0);
        send_request(REQ_REGISTER, CLASS_PRIO, 16'h0013, 0, 8'd9, 0);
        // common tasks: once-only, counted, endless, never due
        send_request(REQ_REGISTER, CLASS_COMMON, 16'h0020, 32'd0, 8'd0, 8'd0);
        send_request(REQ_REGISTER, CLASS_COMMON, 16'h0021, 32'd5, 8'd255, 8'd1);
        send_request(REQ_REGISTER, CLASS_COMMON, 16'h0022, 32'd0, 8'd255, NEVER_EXPIRES);
        send_request(REQ_REGISTER, CLASS_COMMON, 16'h0023, 32'hFFFF_FFFF, 8'd1, 8'd3);
        send_request(REQ_DISPATCH, 2'd0, 0, 0, 0, 0);
        // unregisters after the adds took effect: hits, a repeat and a miss
        send_request(REQ_UNREGISTER, CLASS_PRIO, 16'h0011, 0, 0, 0);
        send_request(REQ_UNREGISTER, CLASS_PRIO, 16'h0011, 0, 0, 0);
        send_request(REQ_UNREGISTER, CLASS_PRIO, 16'h0099, 0, 0, 0);
        send_request(REQ_UNREGISTER, CLASS_COMMON, 16'h0022, 0, 0, 0);
        now_t = 32'd110;
        send_request(REQ_DISPATCH, 2'd0, 0, 0, 0, 0);
        // unknown class and unknown request type
        send_request(REQ_REGISTER, 2'd3, 16'h0030, 0, 0, 0);
        send_request(REQ_UNREGISTER, 2'd3, 16'h0030, 0, 0, 0);
        send_request(2'd3, 2'd3, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        // time wraps past zero
        now_t = 32'hFFFF_FFF0;
        send_request(REQ_REGISTER, CLASS_COMMON, 16'h0024, 32'd20, 8'd128, 8'd2);
        send_request(REQ_DISPATCH, 2'd0, 0, 0, 0, 0);
        now_t = 32'd8;
        send_request(REQ_DISPATCH, 2'd0, 0, 0, 0, 0);

        repeat (RANDOM_ITEMS) random_request();
        @(negedge clk) s_tvalid <= 1'b0;

        while (waiting != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
